// ===== rtl/core/drm_pkg.sv =====
// ----------------------------------------------------------------------------
// drm_pkg
// Shared types, constants and calendar helper functions for the date
// recurrence matcher.
// ----------------------------------------------------------------------------
package drm_pkg;

    // Field widths.
    localparam int KIND_W  = 3;
    localparam int DATE_W  = 27;
    localparam int YEAR_W  = 14;
    localparam int REM_W   = 14;
    localparam int MONTH_W = 7;
    localparam int DAY_W   = 7;
    localparam int MLEN_W  = 5;
    localparam int CUM_W   = 12;
    localparam int OFS_W   = 23;

    // Recurrence kinds.
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DAILY   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WEEKLY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MONTHLY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_YEARLY  = 3'd4;

    // Month numbers used by the yearly leap-day rule.
    localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
    localparam logic [DAY_W-1:0]   DAY_28    = 7'd28;
    localparam logic [DAY_W-1:0]   DAY_29    = 7'd29;

    // Reciprocal of 10000: floor(v * YEAR_RECIP / 2**YEAR_SHIFT) == v / 10000
    // for every 27-bit v.
    localparam logic [DATE_W-1:0] YEAR_RECIP = 27'd109951163;
    localparam int                YEAR_SHIFT = 40;

    // Reciprocal of 100, exact for operands below 43690.
    localparam logic [DATE_W-1:0] DIV100_RECIP = 27'd10486;
    localparam int                DIV100_SHIFT = 20;

    // Bias folded into the day count. It removes the days before 2000,
    // adds the Saturday offset and the minus one of the day of month, and
    // adds a multiple of seven so that the count is never negative:
    // 7 * 2**17 + 6 - 1 - 730485.
    localparam logic [OFS_W-1:0] DAY_BIAS = 23'd187024;

    // Per-date information handed from the date unit to the decision logic.
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               leap;
        logic [MLEN_W-1:0]  mlen;
        logic [OFS_W-1:0]   day_ofs;
    } date_info_t;

    // Stage load enables of the date pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_adv_t;

    // Length of a month; months outside the calendar count thirty days.
    function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [MLEN_W-1:0] len;
        len = 5'd30;
        case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    // Days in the months that come before month m of the same year.
    function automatic logic [CUM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m,
                                                           input logic leap);
        logic [CUM_W-1:0] cum;
        cum = '0;
        case (m)
            7'd0, 7'd1: cum = 12'd0;
            7'd2:    cum = 12'd31;
            7'd3:    cum = 12'd59;
            7'd4:    cum = 12'd90;
            7'd5:    cum = 12'd120;
            7'd6:    cum = 12'd151;
            7'd7:    cum = 12'd181;
            7'd8:    cum = 12'd212;
            7'd9:    cum = 12'd243;
            7'd10:   cum = 12'd273;
            7'd11:   cum = 12'd304;
            7'd12:   cum = 12'd334;
            default: cum = 12'd365 + CUM_W'(m - 7'd13) * 12'd30;
        endcase
        if (leap && (m >= 7'd3))
        begin
            cum = cum + 12'd1;
        end
        return cum;
    endfunction

    // Residue modulo seven, using 8 == 1 (mod 7) to sum octal digits.
    function automatic logic [2:0] mod7(input logic [OFS_W-1:0] x);
        logic [23:0] xx;
        logic [5:0]  s1;
        logic [3:0]  s2;
        logic [2:0]  s3;
        xx = {1'b0, x};
        s1 = '0;
        for (int i = 0; i < 8; i++)
        begin
            s1 = s1 + 6'(xx[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 3'(s2[3]) + s2[2:0];
        return (s3 == 3'd7) ? 3'd0 : s3;
    endfunction

endpackage

// ===== rtl/core/drm_date_unit.sv =====
// ----------------------------------------------------------------------------
// drm_date_unit
// Four-stage pipeline that splits a YYYYMMDD value into year, month and
// day and forms a biased Gregorian day count for one date.
// ----------------------------------------------------------------------------
module drm_date_unit (
    input  logic                        clk,
    input  drm_pkg::stage_adv_t         adv,
    input  logic [drm_pkg::DATE_W-1:0]  date,
    output drm_pkg::date_info_t         info
);

    localparam int YW = drm_pkg::YEAR_W;
    localparam int RW = drm_pkg::REM_W;
    localparam int DW = drm_pkg::DATE_W;
    localparam int OW = drm_pkg::OFS_W;

    // Stage 1 registers.
    logic [YW-1:0] year1_reg, year1_next;
    logic [DW-1:0] val1_reg;

    // Stage 2 registers.
    logic [YW-1:0] year2_reg;
    logic [RW-1:0] rem2_reg, rem2_next;
    logic [7:0]    yq2_reg, yq2_next;
    logic [7:0]    q100_2_reg, q100_2_next;
    logic [5:0]    q400_2_reg, q400_2_next;

    // Stage 3 registers.
    logic [RW-1:0]                   rem3_reg;
    logic [drm_pkg::MONTH_W-1:0]     month3_reg, month3_next;
    logic [OW-1:0]                   base3_reg, base3_next;
    logic                            leap3_reg, leap3_next;

    // Stage 4 register.
    drm_pkg::date_info_t             info4_reg, info4_next;

    // Intermediate products.
    logic [53:0]   year_prod;
    logic [27:0]   yq_prod;
    logic [27:0]   q100_prod;
    logic [27:0]   q400_prod;
    logic [26:0]   month_prod;
    logic [YW-1:0] q4;
    logic [OW-1:0] year_days;
    logic [RW-1:0] day_full;

    // Stage 1: year by reciprocal multiplication.
    always_comb
    begin
        year_prod  = 54'(date) * 54'(drm_pkg::YEAR_RECIP);
        year1_next = year_prod[drm_pkg::YEAR_SHIFT +: YW];
    end

    // Stage 2: remainder within the year and the century quotients.
    always_comb
    begin
        rem2_next   = RW'(val1_reg - DW'(year1_reg) * DW'(10000));
        yq_prod     = 28'(year1_reg) * 28'(drm_pkg::DIV100_RECIP);
        q100_prod   = 28'(year1_reg + YW'(99)) * 28'(drm_pkg::DIV100_RECIP);
        q400_prod   = 28'((year1_reg + YW'(399)) >> 2) * 28'(drm_pkg::DIV100_RECIP);
        yq2_next    = yq_prod[drm_pkg::DIV100_SHIFT +: 8];
        q100_2_next = q100_prod[drm_pkg::DIV100_SHIFT +: 8];
        q400_2_next = q400_prod[drm_pkg::DIV100_SHIFT +: 6];
    end

    // Stage 3: month, days before the year and the leap-year flag.
    always_comb
    begin
        month_prod  = 27'(rem2_reg) * 27'(drm_pkg::DIV100_RECIP);
        month3_next = month_prod[drm_pkg::DIV100_SHIFT +: drm_pkg::MONTH_W];
        q4          = (year2_reg + YW'(3)) >> 2;
        year_days   = OW'(year2_reg) * OW'(365) + OW'(q4) + OW'(q400_2_reg);
        base3_next  = year_days - OW'(q100_2_reg) + drm_pkg::DAY_BIAS;
        if (year2_reg == YW'(yq2_reg) * YW'(100))
        begin
            leap3_next = (yq2_reg[1:0] == 2'd0);
        end
        else
        begin
            leap3_next = (year2_reg[1:0] == 2'd0);
        end
    end

    // Stage 4: day of month, month length and the full day count.
    always_comb
    begin
        day_full           = rem3_reg - RW'(month3_reg) * RW'(100);
        info4_next.month   = month3_reg;
        info4_next.day     = day_full[drm_pkg::DAY_W-1:0];
        info4_next.leap    = leap3_reg;
        info4_next.mlen    = drm_pkg::month_len(month3_reg, leap3_reg);
        info4_next.day_ofs = base3_reg
                           + OW'(drm_pkg::days_before_month(month3_reg, leap3_reg))
                           + OW'(day_full[drm_pkg::DAY_W-1:0]);
    end

    // Payload registers, each loaded when its stage advances.
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            year1_reg <= year1_next;
            val1_reg  <= date;
        end
        if (adv.s2)
        begin
            year2_reg  <= year1_reg;
            rem2_reg   <= rem2_next;
            yq2_reg    <= yq2_next;
            q100_2_reg <= q100_2_next;
            q400_2_reg <= q400_2_next;
        end
        if (adv.s3)
        begin
            rem3_reg   <= rem2_reg;
            month3_reg <= month3_next;
            base3_reg  <= base3_next;
            leap3_reg  <= leap3_next;
        end
        if (adv.s4)
        begin
            info4_reg <= info4_next;
        end
    end

    assign info = info4_reg;

endmodule

// ===== rtl/core/drm_decide.sv =====
// ----------------------------------------------------------------------------
// drm_decide
// Applies the recurrence rule of the transaction to the decoded base and
// check dates.
// ----------------------------------------------------------------------------
module drm_decide (
    input  logic [drm_pkg::KIND_W-1:0] kind,
    input  logic                       same,
    input  logic                       before_base,
    input  drm_pkg::date_info_t        base_info,
    input  drm_pkg::date_info_t        check_info,
    output logic                       fires
);

    localparam int DW = drm_pkg::DAY_W;

    logic same_weekday;
    logic monthly_hit;
    logic yearly_hit;

    // Rule terms for each periodic kind.
    always_comb
    begin
        same_weekday = (drm_pkg::mod7(base_info.day_ofs) == drm_pkg::mod7(check_info.day_ofs));
        monthly_hit  = (base_info.day == check_info.day)
                    || ((base_info.day > DW'(check_info.mlen))
                        && (check_info.day == DW'(check_info.mlen)));
        yearly_hit   = ((base_info.month == check_info.month)
                        && (base_info.day == check_info.day))
                    || ((base_info.month == drm_pkg::MONTH_FEB)
                        && (base_info.day == drm_pkg::DAY_29)
                        && (check_info.month == drm_pkg::MONTH_FEB)
                        && (check_info.day == drm_pkg::DAY_28)
                        && !check_info.leap);
    end

    // Selection by kind; a check date before the base never fires.
    always_comb
    begin
        if (kind == drm_pkg::KIND_NONE)
        begin
            fires = same;
        end
        else if (before_base)
        begin
            fires = 1'b0;
        end
        else if (same)
        begin
            fires = 1'b1;
        end
        else
        begin
            case (kind)
                drm_pkg::KIND_DAILY:   fires = 1'b1;
                drm_pkg::KIND_WEEKLY:  fires = same_weekday;
                drm_pkg::KIND_MONTHLY: fires = monthly_hit;
                drm_pkg::KIND_YEARLY:  fires = yearly_hit;
                default:               fires = 1'b0;
            endcase
        end
    end

endmodule

// ===== rtl/core/date_recurrence_match.sv =====
// ----------------------------------------------------------------------------
// date_recurrence_match
// Tests whether a recurring event (none, daily, weekly, monthly, yearly)
// falls on a check date, given its base date, both in YYYYMMDD form.
// ----------------------------------------------------------------------------
// One transaction is accepted every clock cycle while the input is not
// stalled. Each passes through the input register, the stages of the
// date decoding pipeline and the output register: the split into year,
// month and day and the day count are done with constant reciprocal
// multipliers, one multiplier deep per stage, and the rule is evaluated
// into the output register. Every stage advances on its own, so bubbles
// close up behind a stalled output and the input stalls only once the
// whole pipeline is full.
// ----------------------------------------------------------------------------
module date_recurrence_match (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [drm_pkg::KIND_W-1:0]  recurrence_kind,
    input  logic [drm_pkg::DATE_W-1:0]  base_date,
    input  logic [drm_pkg::DATE_W-1:0]  check_date,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        fires
);

    localparam int NSTAGE = 6;

    typedef struct packed {
        logic [drm_pkg::KIND_W-1:0] kind;
        logic                       same;
        logic                       before_base;
    } ctl_t;

    logic [NSTAGE-1:0]            valid_reg;
    logic [NSTAGE-1:0]            ready;
    drm_pkg::stage_adv_t          adv;

    logic [drm_pkg::KIND_W-1:0]   kind0_reg;
    logic [drm_pkg::DATE_W-1:0]   base0_reg;
    logic [drm_pkg::DATE_W-1:0]   check0_reg;
    ctl_t                         ctl_reg [1:4];
    ctl_t                         ctl1_next;
    logic                         fires_reg, fires_next;

    drm_pkg::date_info_t          base_info;
    drm_pkg::date_info_t          check_info;

    // A stage may load when it is empty or its successor can load.
    always_comb
    begin
        ready[NSTAGE-1] = !valid_reg[NSTAGE-1] || !out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        adv.s1 = ready[1];
        adv.s2 = ready[2];
        adv.s3 = ready[3];
        adv.s4 = ready[4];
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Whole-date comparison made on the raw values.
    always_comb
    begin
        ctl1_next.kind        = kind0_reg;
        ctl1_next.same        = (base0_reg == check0_reg);
        ctl1_next.before_base = (check0_reg < base0_reg);
    end

    // Input register, control pipeline and result register.
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            kind0_reg  <= recurrence_kind;
            base0_reg  <= base_date;
            check0_reg <= check_date;
        end
        if (ready[1])
        begin
            ctl_reg[1] <= ctl1_next;
        end
        for (int k = 2; k <= 4; k++)
        begin
            if (ready[k])
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
        if (ready[5])
        begin
            fires_reg <= fires_next;
        end
    end

    // Date decoding for the base date.
    drm_date_unit u_base_unit (
        .clk  (clk),
        .adv  (adv),
        .date (base0_reg),
        .info (base_info)
    );

    // Date decoding for the check date.
    drm_date_unit u_check_unit (
        .clk  (clk),
        .adv  (adv),
        .date (check0_reg),
        .info (check_info)
    );

    // Recurrence rule.
    drm_decide u_decide (
        .kind        (ctl_reg[4].kind),
        .same        (ctl_reg[4].same),
        .before_base (ctl_reg[4].before_base),
        .base_info   (base_info),
        .check_info  (check_info),
        .fires       (fires_next)
    );

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NSTAGE-1];
    assign fires     = fires_reg;

endmodule
